[design/sph_pkg.sv]
// Shared types, constants and the modular add and subtract helpers for the substring hash block.
package sph_pkg;

  localparam int unsigned MaxLen  = 4096;
  localparam int unsigned AddrW   = $clog2(MaxLen);
  localparam int unsigned LenW    = AddrW + 1;
  localparam int unsigned HashW   = 30;
  localparam logic [HashW-1:0] HashMod   = 30'd1000000007;
  localparam logic [HashW-1:0] HashBase  = 30'd17;
  // Inverse of 17 modulo 1000000007, worked out once.
  localparam logic [HashW-1:0] BaseInv   = 30'd352941179;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_REV  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOSTRING = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       char_byte;
    logic             is_final;
    logic [AddrW-1:0] first_index;
    logic [AddrW-1:0] last_index;
  } in_item_t;

  typedef struct packed {
    logic [HashW-1:0] hash_value;
    logic [1:0]       status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_MUL,
    S_LD_WR,
    S_BK_RD,
    S_BK_MUL,
    S_BK_WR,
    S_Q_RD1,
    S_Q_RD2,
    S_Q_MUL,
    S_Q_WAIT,
    S_OUT
  } state_t;

  // Operands handed to the shared modular multiplier.
  typedef struct packed {
    logic             start;
    logic [HashW-1:0] a;
    logic [HashW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] p;
  } mul_rsp_t;

  function automatic logic [HashW-1:0] add_mod(input logic [HashW-1:0] x,
                                               input logic [HashW-1:0] y);
    logic [HashW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, HashMod}) s = s - {1'b0, HashMod};
    return s[HashW-1:0];
  endfunction

  function automatic logic [HashW-1:0] sub_mod(input logic [HashW-1:0] x,
                                               input logic [HashW-1:0] y);
    logic [HashW:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + {1'b0, HashMod} - {1'b0, y};
    return s[HashW-1:0];
  endfunction

endpackage

[design/sph_mulmod.sv]
// Shift-and-add modular multiplier: one bit of the multiplier per cycle.
module sph_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  sph_pkg::mul_req_t req,
  output sph_pkg::mul_rsp_t rsp
);
  import sph_pkg::*;

  localparam int unsigned CntW = $clog2(HashW + 1);

  logic [HashW-1:0] acc_r, acc_nxt;
  logic [HashW-1:0] b_r, b_nxt;
  logic [HashW-1:0] a_r, a_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [HashW-1:0] dbl;

  // Horner form from the top bit: acc = 2*acc + bit*a, each kept below the modulus.
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dbl      = add_mod(acc_r, acc_r);
    if (req.start) begin
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      cnt_nxt  = CntW'(HashW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = b_r[HashW-1] ? add_mod(dbl, a_r) : dbl;
      b_nxt   = {b_r[HashW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

[design/substring_polynomial_hash_core.sv]
// Top level of the substring polynomial hash block: sequencer and tables.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one command per beat:
//   a load appends a byte (is_final closes the string), a forward or
//   reversed query asks for the hash of bytes first..last inclusive.
//   Output channel out_valid/out_ready/out_data returns one beat per query
//   (none for a load or the unused command) with hash and status.
// Operation:
//   All modular products go through one shared bit-serial multiplier. A
//   load takes three products (none for the first byte). The final load
//   adds a backward pass of one product per byte. A query takes two table
//   reads and at most one product.
//   One item is worked on at a time; in_ready is low while it runs and
//   while a result beat waits.
// Reset:
//   rst_n (synchronous, active low) clears the length and the complete
//   flag; table contents are left as they are and are never read unwritten.
// Stall:
//   A result beat holds on out_data until out_ready; no input is taken then.
module substring_polynomial_hash_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sph_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sph_pkg::out_item_t out_data
);
  import sph_pkg::*;

  logic [7:0]       byte_mem   [MaxLen];
  logic [HashW-1:0] pow_mem    [MaxLen];
  logic [HashW-1:0] ipow_mem   [MaxLen];
  logic [HashW-1:0] fwd_mem    [MaxLen];
  logic [HashW-1:0] rev_mem    [MaxLen];

  state_t           state_r, state_nxt;
  in_item_t         item_r;
  logic [LenW-1:0]  len_r, len_nxt;
  logic             done_str_r, done_str_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [AddrW-1:0] k_r, k_nxt;
  logic [HashW-1:0] run_r, run_nxt;
  logic [HashW-1:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  out_item_t        res_r, res_nxt;

  // Registered read ports.
  logic [7:0]       byte_rd;
  logic [HashW-1:0] pow_rd, ipow_rd, fwd_rd, fwd_rd2, rev_rd, rev_rd2;
  logic [AddrW-1:0] ra_pow, ra_ipow, ra_fwd, ra_fwd2, ra_rev, ra_rev2, ra_byte;

  logic             wr_load, wr_rev;
  logic [AddrW-1:0] wa;
  logic [HashW-1:0] w_pow, w_ipow, w_fwd;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  sph_mulmod u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  logic [AddrW-1:0] li;
  assign li = len_r[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (wr_load) begin
      byte_mem[wa] <= item_r.char_byte;
      pow_mem[wa]  <= w_pow;
      ipow_mem[wa] <= w_ipow;
      fwd_mem[wa]  <= w_fwd;
    end
    if (wr_rev) rev_mem[k_r] <= run_nxt;
    byte_rd <= byte_mem[ra_byte];
    pow_rd  <= pow_mem[ra_pow];
    ipow_rd <= ipow_mem[ra_ipow];
    fwd_rd  <= fwd_mem[ra_fwd];
    fwd_rd2 <= fwd_mem[ra_fwd2];
    rev_rd  <= rev_mem[ra_rev];
    rev_rd2 <= rev_mem[ra_rev2];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_data.cmd))
            CMD_LOAD:         state_nxt = S_LD_RD;
            CMD_FWD, CMD_REV: state_nxt = S_Q_RD1;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_RD:  state_nxt = (len_r >= LenW'(MaxLen)) ? (item_r.is_final ? S_BK_RD : S_IDLE)
                                                     : S_LD_MUL;
      S_LD_MUL: state_nxt = (li == '0) ? S_LD_WR : (mrsp.done && step_r == 2'd2) ? S_LD_WR
                                                                                 : S_LD_MUL;
      S_LD_WR:  state_nxt = item_r.is_final ? S_BK_RD : S_IDLE;
      S_BK_RD:  state_nxt = S_BK_MUL;
      S_BK_MUL: state_nxt = mrsp.done ? S_BK_WR : S_BK_MUL;
      S_BK_WR:  state_nxt = (k_r == '0) ? S_IDLE : S_BK_RD;
      S_Q_RD1:  state_nxt = S_Q_RD2;
      S_Q_RD2:  state_nxt = S_Q_MUL;
      S_Q_MUL:  state_nxt = (res_r.status != ST_OK || !t2_r[0]) ? S_OUT : S_Q_WAIT;
      S_Q_WAIT: state_nxt = mrsp.done ? S_OUT : S_Q_WAIT;
      S_OUT:    state_nxt = out_ready ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    len_nxt      = len_r;
    done_str_nxt = done_str_r;
    step_nxt     = step_r;
    k_nxt        = k_r;
    run_nxt      = run_r;
    t0_nxt       = t0_r;
    t1_nxt       = t1_r;
    t2_nxt       = t2_r;
    res_nxt      = res_r;
    mreq         = '0;
    wr_load      = 1'b0;
    wr_rev       = 1'b0;
    wa           = li;
    w_pow        = t0_r;
    w_ipow       = t1_r;
    w_fwd        = t2_r;
    ra_byte      = k_r;
    ra_pow       = li - 1'b1;
    ra_ipow      = li - 1'b1;
    ra_fwd       = li - 1'b1;
    ra_fwd2      = item_r.first_index - 1'b1;
    ra_rev       = item_r.first_index;
    ra_rev2      = item_r.last_index + 1'b1;
    in_ready     = (state_r == S_IDLE);
    out_valid    = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.cmd == CMD_LOAD && done_str_r) begin
          len_nxt      = '0;
          done_str_nxt = 1'b0;
        end
      end
      S_LD_RD: begin
        step_nxt = 2'd0;
        if (len_r >= LenW'(MaxLen)) begin
          k_nxt   = li - 1'b1;
          run_nxt = '0;
        end
      end
      S_LD_MUL: begin
        if (li == '0) begin
          t0_nxt = 30'd1;
          t1_nxt = 30'd1;
          t2_nxt = {22'd0, item_r.char_byte};
        end else begin
          // Three products in turn: power, inverse power, byte times power.
          unique case (step_r)
            2'd0: begin
              mreq = '{start: 1'b1, a: pow_rd, b: HashBase};
              step_nxt = 2'd1;
            end
            2'd1: if (mrsp.done) begin
              t0_nxt = mrsp.p;
              mreq = '{start: 1'b1, a: ipow_rd, b: BaseInv};
              step_nxt = 2'd3;
            end
            2'd3: if (mrsp.done) begin
              t1_nxt = mrsp.p;
              mreq = '{start: 1'b1, a: t0_r, b: {22'd0, item_r.char_byte}};
              step_nxt = 2'd2;
            end
            default: if (mrsp.done) t2_nxt = add_mod(fwd_rd, mrsp.p);
          endcase
        end
      end
      S_LD_WR: begin
        wr_load  = 1'b1;
        len_nxt  = len_r + 1'b1;
        k_nxt    = li;
        run_nxt  = '0;
        step_nxt = 2'd0;
      end
      S_BK_RD: begin
        ra_byte = k_r;
        ra_pow  = li - 1'b1 - k_r;
      end
      S_BK_MUL: begin
        if (step_r == 2'd0) begin
          mreq = '{start: 1'b1, a: pow_rd, b: {22'd0, byte_rd}};
          step_nxt = 2'd1;
        end
      end
      S_BK_WR: begin
        run_nxt  = add_mod(run_r, t0_r);
        wr_rev   = 1'b1;
        step_nxt = 2'd0;
        k_nxt    = k_r - 1'b1;
        if (k_r == '0) done_str_nxt = 1'b1;
      end
      S_Q_RD1: begin
        ra_fwd  = item_r.last_index;
        ra_ipow = (item_r.cmd == CMD_FWD) ? item_r.first_index
                                          : li - 1'b1 - item_r.last_index;
        res_nxt = '0;
        if (!done_str_r) res_nxt.status = ST_NOSTRING;
        else if (item_r.first_index > item_r.last_index) res_nxt.status = ST_OK;
        else if ({1'b0, item_r.last_index} >= len_r) res_nxt.status = ST_RANGE;
      end
      S_Q_RD2: begin
        // t2 bit 0 flags that a product is needed.
        t2_nxt = '0;
        t2_nxt[0] = (res_r.status == ST_OK) && (item_r.first_index <= item_r.last_index);
        if (item_r.cmd == CMD_FWD)
          t0_nxt = sub_mod(fwd_rd, (item_r.first_index == '0) ? '0 : fwd_rd2);
        else
          t0_nxt = sub_mod(rev_rd, ({1'b0, item_r.last_index} + 1'b1 < len_r) ? rev_rd2
                                                                               : '0);
        t1_nxt = ipow_rd;
      end
      S_Q_MUL: begin
        if (res_r.status == ST_OK && t2_r[0]) mreq = '{start: 1'b1, a: t0_r, b: t1_r};
      end
      S_Q_WAIT: begin
        if (mrsp.done) res_nxt.hash_value = mrsp.p;
      end
      default: ;
    endcase
    if (state_r == S_BK_MUL && mrsp.done) t0_nxt = mrsp.p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      done_str_r <= 1'b0;
      step_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      done_str_r <= done_str_nxt;
      step_r     <= step_nxt;
    end
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    k_r   <= k_nxt;
    run_r <= run_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    t2_r  <= t2_nxt;
    res_r <= res_nxt;
  end

  assign out_data = res_r;

endmodule

[design/sph_checker.sv]
// Port-level checks for the substring hash block, bound to the top level.
module sph_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sph_pkg::in_item_t  in_data,
  input sph_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_ready
);
  import sph_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("status code out of range");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.hash_value == '0)
    else $error("error result carries a hash");

  // The unused command is dropped on the spot, so only real work clears ready.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd != CMD_NONE |=> !in_ready)
    else $error("ready stayed high after a beat");

endmodule

bind substring_polynomial_hash_core sph_checker u_sph_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);

[dv/tb.sv]
// Self-checking testbench for the substring polynomial hash block.
`timescale 1ns / 1ps

module tb;
  import sph_pkg::*;

  localparam longint unsigned Modulus = 64'd1000000007;
  localparam int unsigned CycleLimit = 1000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic in_ready_seen;

  substring_polynomial_hash_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: the string and its tables, held at the block's widths.
  logic [7:0]       str_bytes [MaxLen];
  logic [HashW-1:0] pow_tab [MaxLen];
  logic [HashW-1:0] ipow_tab [MaxLen];
  logic [HashW-1:0] fwd_tab [MaxLen];
  logic [HashW-1:0] rev_tab [MaxLen];
  int unsigned      str_len;
  bit               str_done;

  in_item_t  pending_cmds [$];
  out_item_t expected_hashes [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_cycles;
  bit  errors;
  int unsigned cycle_count;

  function automatic logic [HashW-1:0] mul_m(input logic [HashW-1:0] x,
                                             input logic [HashW-1:0] y);
    longint unsigned p;
    p = (longint'(x) * longint'(y)) % Modulus;
    return p[HashW-1:0];
  endfunction

  function automatic logic [HashW-1:0] add_m(input logic [HashW-1:0] x,
                                             input logic [HashW-1:0] y);
    longint unsigned s;
    s = longint'(x) + longint'(y);
    if (s >= Modulus) s -= Modulus;
    return s[HashW-1:0];
  endfunction

  function automatic logic [HashW-1:0] sub_m(input logic [HashW-1:0] x,
                                             input logic [HashW-1:0] y);
    longint unsigned s;
    s = (x >= y) ? longint'(x) - longint'(y) : longint'(x) + Modulus - longint'(y);
    return s[HashW-1:0];
  endfunction

  // Updates the string model for one accepted beat and queues any result.
  task automatic predict_hash(input in_item_t it);
    int unsigned i;
    int k;
    logic [HashW-1:0] run;
    logic [HashW-1:0] lower;
    out_item_t r;
    begin
      r = '0;
      case (cmd_t'(it.cmd))
        CMD_LOAD: begin
          if (str_done) begin
            str_len = 0;
            str_done = 0;
          end
          if (str_len < MaxLen) begin
            i = str_len;
            str_bytes[i] = it.char_byte;
            if (i == 0) begin
              pow_tab[0] = HashW'(1);
              ipow_tab[0] = HashW'(1);
              fwd_tab[0] = HashW'(it.char_byte);
            end else begin
              pow_tab[i] = mul_m(pow_tab[i-1], HashBase);
              ipow_tab[i] = mul_m(ipow_tab[i-1], BaseInv);
              fwd_tab[i] = add_m(fwd_tab[i-1], mul_m(HashW'(it.char_byte), pow_tab[i]));
            end
            str_len = i + 1;
          end
          if (it.is_final) begin
            run = '0;
            for (k = str_len - 1; k >= 0; k--) begin
              run = add_m(run, mul_m(HashW'(str_bytes[k]), pow_tab[str_len-1-k]));
              rev_tab[k] = run;
            end
            str_done = 1;
          end
        end
        CMD_NONE: ;
        default: begin
          if (!str_done) r.status = ST_NOSTRING;
          else if (it.first_index > it.last_index) r.status = ST_OK;
          else if (it.last_index >= str_len) r.status = ST_RANGE;
          else if (it.cmd == CMD_FWD) begin
            lower = (it.first_index > 0) ? fwd_tab[it.first_index-1] : '0;
            r.hash_value = mul_m(sub_m(fwd_tab[it.last_index], lower),
                                 ipow_tab[it.first_index]);
          end else begin
            lower = (it.last_index + 1 < str_len) ? rev_tab[it.last_index+1] : '0;
            r.hash_value = mul_m(sub_m(rev_tab[it.first_index], lower),
                                 ipow_tab[str_len-1-it.last_index]);
          end
          expected_hashes.push_back(r);
        end
      endcase
    end
  endtask

  function automatic in_item_t make_cmd(input cmd_t c, input logic [7:0] b,
                                        input logic fin, input int f, input int l);
    in_item_t it;
    it.cmd = c;
    it.char_byte = b;
    it.is_final = fin;
    it.first_index = f[AddrW-1:0];
    it.last_index = l[AddrW-1:0];
    return it;
  endfunction

  function automatic in_item_t rand_query(input int len);
    int f;
    int l;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7 && len > 0) begin
      f = $urandom_range(0, len - 1);
      l = $urandom_range(f, len - 1);
    end else begin
      f = $urandom_range(0, MaxLen - 1);
      l = $urandom_range(0, MaxLen - 1);
    end
    return make_cmd($urandom_range(0, 9) == 0 ? CMD_NONE
                    : ($urandom_range(0, 1) ? CMD_FWD : CMD_REV),
                    8'($urandom), 1'($urandom), f, l);
  endfunction

  // Appends a whole string of random bytes; the last beat closes it.
  task automatic queue_string(input int len);
    int j;
    for (j = 0; j < len; j++)
      pending_cmds.push_back(make_cmd(CMD_LOAD, 8'($urandom), j == len - 1,
                                      $urandom, $urandom));
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_hashes.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[substring_polynomial_hash_core] ERROR");
      $finish;
    end
  end

  // Driver: presents beats at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1;
        in_data <= pending_cmds.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver: a long hold-off counts down here, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Acceptance flag from the last rising edge, so the driver knows the beat went.
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) predict_hash(in_data);
  end

  // Monitor: checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t unexpected result: actual hash %0d status %0d", $time,
                 out_data.hash_value, out_data.status);
        errors = 1;
      end else begin
        out_item_t e;
        e = expected_hashes.pop_front();
        if (e.hash_value !== out_data.hash_value)
          begin
            $display("%0t hash mismatch: expected %0d actual %0d", $time,
                     e.hash_value, out_data.hash_value);
            errors = 1;
          end
        if (e.status !== out_data.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time,
                   e.status, out_data.status);
          errors = 1;
        end
      end
    end
  end

  initial begin
    int ph;
    int n;
    int len;
    int q;
    str_len = 0;
    str_done = 0;
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    in_valid = 0;
    in_ready_seen = 0;
    in_data = '0;
    out_ready = 0;
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed: queries before any string, the unused command, extremes.
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_REV, 8'hFF, 1, 4095, 4095));
    pending_cmds.push_back(make_cmd(CMD_NONE, 8'hFF, 1, 4095, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 8'hFF, 0, 4095, 4095));
    pending_cmds.push_back(make_cmd(CMD_REV, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 8'h00, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 8'hA5, 1, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 0, 2));
    pending_cmds.push_back(make_cmd(CMD_REV, 0, 0, 0, 2));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 1, 1));
    pending_cmds.push_back(make_cmd(CMD_REV, 0, 0, 2, 2));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 4095, 0));
    pending_cmds.push_back(make_cmd(CMD_REV, 0, 0, 0, 3));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 0, 4095));
    pending_cmds.push_back(make_cmd(CMD_NONE, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 1, 2));
    // A one-byte string replaces the previous one.
    pending_cmds.push_back(make_cmd(CMD_LOAD, 8'h7F, 1, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_REV, 0, 0, 0, 1));
    wait_drained();

    // Long hold-off on the receiver while the sender keeps offering queries.
    hold_off_cycles = 3000;
    for (q = 0; q < 30; q++) pending_cmds.push_back(rand_query(str_len));
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (n = 0; n < 5; n++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0) begin
          // Broken sequence: a query while a string is only partly loaded.
          pending_cmds.push_back(make_cmd(CMD_LOAD, 8'($urandom), 0, 0, 0));
          pending_cmds.push_back(rand_query(0));
        end
        queue_string(len);
        for (q = 0; q < 22; q++) pending_cmds.push_back(rand_query(len));
      end
      // Sender pauses until everything expected has come back.
      wait_drained();
    end

    // A longer string, then a two-byte string that replaces it, with queries past its top index.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_string(299);
    pending_cmds.push_back(make_cmd(CMD_LOAD, 8'h81, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 8'h42, 1, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 0, 4095));
    pending_cmds.push_back(make_cmd(CMD_REV, 0, 0, 0, 300));
    pending_cmds.push_back(make_cmd(CMD_FWD, 0, 0, 100, 300));
    pending_cmds.push_back(make_cmd(CMD_REV, 0, 0, 4000, 4095));
    wait_drained();

    if (!errors && expected_hashes.size() == 0)
      $display("[substring_polynomial_hash_core] OK");
    else
      $display("[substring_polynomial_hash_core] ERROR");
    $finish;
  end

endmodule

[sim.f]
design/sph_pkg.sv
design/sph_mulmod.sv
design/substring_polynomial_hash_core.sv
design/sph_checker.sv
dv/tb.sv
